// ----- rtl/grid_spanning_tree_walker_defines.svh -----
// Assertion macros for the grid spanning tree walker.
// Each use expects clk and rst_n in scope; empty bodies when SYNTHESIS is defined.
`ifndef GRID_SPANNING_TREE_WALKER_DEFINES_SVH
`define GRID_SPANNING_TREE_WALKER_DEFINES_SVH
`ifndef SYNTHESIS
`define GSTW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GSTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GSTW_ASSERT(lbl, prop, msg)
`define GSTW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/gstw_pkg.sv -----
// Shared types, codes and widths for the grid spanning tree walker.
// No dependencies.
package gstw_pkg;

    localparam int DEF_MAX_SIDE = 32;

    localparam int COORD_W    = 5;
    localparam int MASK_W     = 4;
    localparam int STATUS_W   = 3;
    localparam int MODE_W     = 2;
    localparam int MARK_W     = 2;
    localparam int EPOCH_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LIFO   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIFO   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd2;

    localparam logic [MARK_W-1:0] MARK_UNVISITED = 2'd0;
    localparam logic [MARK_W-1:0] MARK_VISITED   = 2'd1;
    localparam logic [MARK_W-1:0] MARK_PROCESSED = 2'd2;

    localparam logic [STATUS_W-1:0] ST_EXPANDED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PROCESSED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STARTED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 3'd4;

    localparam logic ACT_START = 1'b0;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_POP,
        S_NODE,
        S_NB
    } state_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        logic from_head;
    } dq_ctrl_t;

endpackage

// ----- rtl/grid_spanning_tree_walker.sv -----
// Grid spanning tree walker: node mark memory, walk sequencer and register file.
// Depends on gstw_pkg, gstw_deque and grid_spanning_tree_walker_defines.svh.
//
// Usage:
//   Items enter on start/busy: an item is taken at a rising edge with start high
//   and busy low. action 0 begins a walk at (start_row, start_col); action 1 pops
//   one node and expands it unless it is processed. Each item yields one result on
//   node_row, node_col, edge_mask, status and queue_empty, marked by done for one cycle.
//   Registers are written on cfg_valid/cfg_ready (cfg_ready is always high) with
//   cfg_index selecting row_count, col_count or order_mode.
//   Sequencing: a start or a step on an empty deque is answered from the idle state,
//   done follows in the next cycle and busy stays low, except on a start that wraps
//   the epoch tag and so starts the sweep. A step that finds its node processed does
//   a deque read and a node mark read; an expansion goes on with one mark read-modify-
//   write per neighbour on the mark memory port pair. done rises as busy falls.
//   After reset the mark memory is swept, one entry a cycle, over all 4**clog2(MAX_SIDE)
//   entries (1024 at the default) with busy high. Marks carry an epoch tag so a
//   start needs no sweep, except every eighth start, when the tag wraps and the
//   same sweep runs once more. The receiver cannot stall; done is never held.
`include "grid_spanning_tree_walker_defines.svh"
module grid_spanning_tree_walker
    import gstw_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  action,
    input  logic [COORD_W-1:0]    start_row,
    input  logic [COORD_W-1:0]    start_col,
    input  logic                  take_front,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [COORD_W-1:0]    node_row,
    output logic [COORD_W-1:0]    node_col,
    output logic [MASK_W-1:0]     edge_mask,
    output logic [STATUS_W-1:0]   status,
    output logic                  queue_empty
);

    localparam int CW        = $clog2(MAX_SIDE);
    localparam int MAW       = 2 * CW;
    localparam int MDEPTH    = 1 << MAW;
    localparam int ENTRY_W   = EPOCH_W + MARK_W;
    localparam int SIDE_LAST = MAX_SIDE - 1;

    function automatic logic [MAW-1:0] nb_addr(input logic [1:0] k,
                                               input logic [COORD_W-1:0] r,
                                               input logic [COORD_W-1:0] c);
        logic [COORD_W-1:0] nr;
        logic [COORD_W-1:0] nc;
        nr = r;
        nc = c;
        case (k)
            2'd0:    nc = c - COORD_W'(1);
            2'd1:    nc = c + COORD_W'(1);
            2'd2:    nr = r - COORD_W'(1);
            default: nr = r + COORD_W'(1);
        endcase
        return {CW'(nr), CW'(nc)};
    endfunction

    state_t               state_reg, state_next;
    logic [EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic [MAW-1:0]       sweep_idx_reg, sweep_idx_next;
    logic [COORD_W-1:0]   row_count_reg, col_count_reg;
    logic [MODE_W-1:0]    order_mode_reg;
    logic [COORD_W-1:0]   cur_row_reg, cur_row_next;
    logic [COORD_W-1:0]   cur_col_reg, cur_col_next;
    logic [1:0]           nb_idx_reg, nb_idx_next;
    logic [MASK_W-1:0]    mask_reg, mask_next;
    logic                 done_reg, done_next;
    logic [COORD_W-1:0]   node_row_reg, node_row_next;
    logic [COORD_W-1:0]   node_col_reg, node_col_next;
    logic [MASK_W-1:0]    edge_mask_reg, edge_mask_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 queue_empty_reg, queue_empty_next;

    logic [ENTRY_W-1:0]   mark_mem [MDEPTH];
    logic [ENTRY_W-1:0]   mark_rd_reg;
    logic                 mark_we;
    logic [MAW-1:0]       mark_waddr;
    logic [ENTRY_W-1:0]   mark_wdata;
    logic                 mark_re;
    logic [MAW-1:0]       mark_raddr;
    logic [MARK_W-1:0]    mark_eff;

    dq_ctrl_t             dq_ctrl;
    logic [MAW-1:0]       dq_push_data;
    logic [MAW-1:0]       dq_pop_data;
    logic [MAW:0]         dq_count;

    logic [COORD_W-1:0]   row_max, col_max;
    logic [3:0]           nb_exists;
    logic                 accept;
    logic                 in_range;
    logic                 nb_new;

    gstw_deque #(
        .MAX_SIDE (MAX_SIDE)
    ) u_deque (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dq_ctrl),
        .push_data (dq_push_data),
        .pop_data  (dq_pop_data),
        .count     (dq_count)
    );

    assign row_max = (32'(row_count_reg) > SIDE_LAST) ? COORD_W'(SIDE_LAST) : row_count_reg;
    assign col_max = (32'(col_count_reg) > SIDE_LAST) ? COORD_W'(SIDE_LAST) : col_count_reg;

    assign nb_exists[0] = cur_col_reg != '0;
    assign nb_exists[1] = ({1'b0, cur_col_reg} + 6'd1) <= {1'b0, col_max};
    assign nb_exists[2] = cur_row_reg != '0;
    assign nb_exists[3] = ({1'b0, cur_row_reg} + 6'd1) <= {1'b0, row_max};

    assign mark_eff = (mark_rd_reg[ENTRY_W-1:MARK_W] == epoch_reg) ?
                      mark_rd_reg[MARK_W-1:0] : MARK_UNVISITED;

    assign busy      = state_reg != S_IDLE;
    assign accept    = start && (state_reg == S_IDLE);
    assign in_range  = (start_row <= row_max) && (start_col <= col_max);
    assign nb_new    = nb_exists[nb_idx_reg] && (mark_eff == MARK_UNVISITED);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        epoch_next       = epoch_reg;
        sweep_idx_next   = sweep_idx_reg;
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        nb_idx_next      = nb_idx_reg;
        mask_next        = mask_reg;
        done_next        = 1'b0;
        node_row_next    = node_row_reg;
        node_col_next    = node_col_reg;
        edge_mask_next   = edge_mask_reg;
        status_next      = status_reg;
        queue_empty_next = queue_empty_reg;
        mark_we          = 1'b0;
        mark_waddr       = sweep_idx_reg;
        mark_wdata       = {epoch_reg, MARK_UNVISITED};
        mark_re          = 1'b0;
        mark_raddr       = nb_addr(2'd0, cur_row_reg, cur_col_reg);
        dq_ctrl          = '0;
        dq_push_data     = {CW'(start_row), CW'(start_col)};

        case (state_reg)
            S_SWEEP:
            begin
                mark_we        = 1'b1;
                sweep_idx_next = sweep_idx_reg + MAW'(1);
                if (sweep_idx_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    if (action == ACT_START)
                    begin
                        dq_ctrl.clear    = 1'b1;
                        dq_ctrl.push     = in_range;
                        node_row_next    = start_row;
                        node_col_next    = start_col;
                        edge_mask_next   = '0;
                        status_next      = in_range ? ST_STARTED : ST_OUT_RANGE;
                        queue_empty_next = !in_range;
                        if (epoch_reg == '1)
                        begin
                            epoch_next     = '0;
                            sweep_idx_next = '0;
                            state_next     = S_SWEEP;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                        end
                    end
                    else if (dq_count == '0)
                    begin
                        node_row_next    = '0;
                        node_col_next    = '0;
                        edge_mask_next   = '0;
                        status_next      = ST_EMPTY;
                        queue_empty_next = 1'b1;
                    end
                    else
                    begin
                        done_next         = 1'b0;
                        dq_ctrl.pop       = 1'b1;
                        dq_ctrl.from_head = (order_mode_reg == MODE_FIFO) ||
                                            ((order_mode_reg == MODE_RANDOM) && take_front);
                        state_next        = S_POP;
                    end
                end
            end
            S_POP:
            begin
                cur_row_next = COORD_W'(dq_pop_data[MAW-1:CW]);
                cur_col_next = COORD_W'(dq_pop_data[CW-1:0]);
                mark_re      = 1'b1;
                mark_raddr   = dq_pop_data;
                state_next   = S_NODE;
            end
            S_NODE:
            begin
                if (mark_eff == MARK_PROCESSED)
                begin
                    done_next        = 1'b1;
                    node_row_next    = cur_row_reg;
                    node_col_next    = cur_col_reg;
                    edge_mask_next   = '0;
                    status_next      = ST_PROCESSED;
                    queue_empty_next = dq_count == '0;
                    state_next       = S_IDLE;
                end
                else
                begin
                    mark_we     = 1'b1;
                    mark_waddr  = {CW'(cur_row_reg), CW'(cur_col_reg)};
                    mark_wdata  = {epoch_reg, MARK_PROCESSED};
                    mark_re     = 1'b1;
                    mark_raddr  = nb_addr(2'd0, cur_row_reg, cur_col_reg);
                    nb_idx_next = 2'd0;
                    mask_next   = '0;
                    state_next  = S_NB;
                end
            end
            S_NB:
            begin
                mark_waddr   = nb_addr(nb_idx_reg, cur_row_reg, cur_col_reg);
                mark_wdata   = {epoch_reg, MARK_VISITED};
                dq_push_data = nb_addr(nb_idx_reg, cur_row_reg, cur_col_reg);
                if (nb_new)
                begin
                    mark_we      = 1'b1;
                    dq_ctrl.push = 1'b1;
                    mask_next    = mask_reg | (MASK_W'(1) << nb_idx_reg);
                end
                if (nb_idx_reg != 2'd3)
                begin
                    mark_re     = 1'b1;
                    mark_raddr  = nb_addr(nb_idx_reg + 2'd1, cur_row_reg, cur_col_reg);
                    nb_idx_next = nb_idx_reg + 2'd1;
                end
                else
                begin
                    done_next        = 1'b1;
                    node_row_next    = cur_row_reg;
                    node_col_next    = cur_col_reg;
                    edge_mask_next   = mask_next;
                    status_next      = ST_EXPANDED;
                    queue_empty_next = !nb_new && (dq_count == '0);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            epoch_reg     <= '0;
            sweep_idx_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            sweep_idx_reg <= sweep_idx_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= COORD_W'(15);
            col_count_reg  <= COORD_W'(15);
            order_mode_reg <= MODE_LIFO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW_COUNT:  row_count_reg  <= cfg_data;
                REG_COL_COUNT:  col_count_reg  <= cfg_data;
                REG_ORDER_MODE: order_mode_reg <= cfg_data[MODE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg     <= cur_row_next;
        cur_col_reg     <= cur_col_next;
        nb_idx_reg      <= nb_idx_next;
        mask_reg        <= mask_next;
        node_row_reg    <= node_row_next;
        node_col_reg    <= node_col_next;
        edge_mask_reg   <= edge_mask_next;
        status_reg      <= status_next;
        queue_empty_reg <= queue_empty_next;
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (mark_re)
        begin
            mark_rd_reg <= mark_mem[mark_raddr];
        end
    end

    assign done        = done_reg;
    assign node_row    = node_row_reg;
    assign node_col    = node_col_reg;
    assign edge_mask   = edge_mask_reg;
    assign status      = status_reg;
    assign queue_empty = queue_empty_reg;

    `GSTW_ASSERT(a_empty_result, (done_reg && status_reg == ST_EMPTY) |-> (queue_empty_reg && edge_mask_reg == '0), "empty step with edges")
    `GSTW_ASSERT(a_edges_expanded, (done_reg && edge_mask_reg != '0) |-> (status_reg == ST_EXPANDED), "edges without expansion")
    `GSTW_ASSERT_NEXT(a_pop_enter, accept && action && dq_count != '0, state_reg == S_POP, "step did not pop")
    `GSTW_ASSERT(a_nb_write_only_new, (state_reg == S_NB && mark_we) |-> dq_ctrl.push, "mark set without push")

endmodule

// ----- rtl/gstw_deque.sv -----
// Node deque: a one-port-write, one-port-read memory with head pointer and count.
// Depends on gstw_pkg and grid_spanning_tree_walker_defines.svh.
`include "grid_spanning_tree_walker_defines.svh"
module gstw_deque
    import gstw_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dq_ctrl_t                  ctrl,
    input  logic [2*$clog2(MAX_SIDE)-1:0] push_data,
    output logic [2*$clog2(MAX_SIDE)-1:0] pop_data,
    output logic [2*$clog2(MAX_SIDE):0]   count
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int NW    = 2 * CW;
    localparam int CNT_W = NW + 1;
    localparam int DEPTH = 1 << NW;
    localparam int CELLS = MAX_SIDE * MAX_SIDE;

    logic [NW-1:0]    mem [DEPTH];
    logic [NW-1:0]    pop_data_reg;
    logic [NW-1:0]    head_reg;
    logic [NW-1:0]    head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr_en;
    logic [NW-1:0]    wr_addr;
    logic [NW-1:0]    rd_addr;
    logic             full;

    assign full = 32'(count_reg) >= CELLS;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg + count_reg[NW-1:0];
        rd_addr    = head_reg + count_reg[NW-1:0] - NW'(1);
        if (ctrl.clear)
        begin
            head_next  = '0;
            count_next = ctrl.push ? CNT_W'(1) : '0;
            wr_en      = ctrl.push;
            wr_addr    = '0;
        end
        else if (ctrl.pop)
        begin
            if (ctrl.from_head)
            begin
                rd_addr   = head_reg;
                head_next = head_reg + NW'(1);
            end
            count_next = count_reg - CNT_W'(1);
        end
        else if (ctrl.push && !full)
        begin
            wr_en      = 1'b1;
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= push_data;
        end
        if (ctrl.pop)
        begin
            pop_data_reg <= mem[rd_addr];
        end
    end

    assign pop_data = pop_data_reg;
    assign count    = count_reg;

    `GSTW_ASSERT(a_pop_nonempty, ctrl.pop |-> (count_reg != '0), "pop from empty deque")
    `GSTW_ASSERT(a_no_push_pop, !(ctrl.pop && ctrl.push), "push and pop in one cycle")
    `GSTW_ASSERT(a_count_bound, 32'(count_reg) <= CELLS, "deque count beyond capacity")
    `GSTW_ASSERT_NEXT(a_clear_count, ctrl.clear, count_reg <= CNT_W'(1), "clear left entries")

endmodule

// ----- tb/sv/tb_grid_spanning_tree_walker.sv -----
// Self-checking bench for grid_spanning_tree_walker: runs directed and random walks
// with register writes between them, predicts every result and compares it by field.
// Depends on gstw_pkg and the grid_spanning_tree_walker RTL.
module tb_grid_spanning_tree_walker;
    import gstw_pkg::*;

    localparam int SIDE        = DEF_MAX_SIDE;
    localparam int CELLS       = SIDE * SIDE;
    localparam int ITEM_TARGET = 2000;
    localparam int CYCLE_LIMIT = 2000000;

    localparam logic                 ACT_EXPAND = 1'b1;
    localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [MASK_W-1:0]   mask;
        logic [STATUS_W-1:0] code;
        logic                qe;
    } step_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  action;
    logic [COORD_W-1:0]    start_row;
    logic [COORD_W-1:0]    start_col;
    logic                  take_front;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    logic [COORD_W-1:0]    node_row;
    logic [COORD_W-1:0]    node_col;
    logic [MASK_W-1:0]     edge_mask;
    logic [STATUS_W-1:0]   status;
    logic                  queue_empty;

    logic [MARK_W-1:0]  node_mark [CELLS];
    int                 queued_node [CELLS];
    int                 dq_head;
    int                 dq_count;
    logic [COORD_W-1:0] rows_reg;
    logic [COORD_W-1:0] cols_reg;
    logic [MODE_W-1:0]  mode_reg;

    step_report_t step_reports [$];
    step_report_t want;
    int           faults;
    int           items_sent;
    int unsigned  cycles;
    bit           gaps_on;

    grid_spanning_tree_walker u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .start_row   (start_row),
        .start_col   (start_col),
        .take_front  (take_front),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .node_row    (node_row),
        .node_col    (node_col),
        .edge_mask   (edge_mask),
        .status      (status),
        .queue_empty (queue_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void enqueue_node(int idx);
        if (dq_count >= CELLS)
            return;
        queued_node[(dq_head + dq_count) % CELLS] = idx;
        dq_count++;
    endfunction

    function automatic bit visit_node(int idx);
        if (node_mark[idx] != MARK_UNVISITED)
            return 1'b0;
        enqueue_node(idx);
        node_mark[idx] = MARK_VISITED;
        return 1'b1;
    endfunction

    function automatic step_report_t walk_step(logic act, logic [COORD_W-1:0] sr,
                                               logic [COORD_W-1:0] sc, logic tf);
        step_report_t r;
        int rmax;
        int cmax;
        int node;
        int nr;
        int nc;
        bit front;
        r = '0;
        rmax = int'(rows_reg);
        cmax = int'(cols_reg);
        if (act == ACT_START)
        begin
            foreach (node_mark[i])
                node_mark[i] = MARK_UNVISITED;
            dq_head = 0;
            dq_count = 0;
            r.row = sr;
            r.col = sc;
            if (int'(sr) > rmax || int'(sc) > cmax)
                r.code = ST_OUT_RANGE;
            else
            begin
                enqueue_node(int'(sr) * SIDE + int'(sc));
                r.code = ST_STARTED;
            end
        end
        else if (dq_count == 0)
            r.code = ST_EMPTY;
        else
        begin
            front = (mode_reg == MODE_FIFO) || (mode_reg == MODE_RANDOM && tf);
            if (front)
            begin
                node = queued_node[dq_head];
                dq_head = (dq_head + 1) % CELLS;
            end
            else
                node = queued_node[(dq_head + dq_count - 1) % CELLS];
            dq_count--;
            nr = node / SIDE;
            nc = node % SIDE;
            r.row = COORD_W'(nr);
            r.col = COORD_W'(nc);
            if (node_mark[node] == MARK_PROCESSED)
                r.code = ST_PROCESSED;
            else
            begin
                node_mark[node] = MARK_PROCESSED;
                if (nc >= 1 && visit_node(node - 1))
                    r.mask[0] = 1'b1;
                if (nc + 1 <= cmax && visit_node(node + 1))
                    r.mask[1] = 1'b1;
                if (nr >= 1 && visit_node(node - SIDE))
                    r.mask[2] = 1'b1;
                if (nr + 1 <= rmax && visit_node(node + SIDE))
                    r.mask[3] = 1'b1;
                r.code = ST_EXPANDED;
            end
        end
        r.qe = (dq_count == 0);
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (step_reports.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: row %0d col %0d mask %b status %0d empty %0d",
                             node_row, node_col, edge_mask, status, queue_empty);
            end
            else
            begin
                want = step_reports[0];
                step_reports.delete(0);
                if (node_row !== want.row || node_col !== want.col
                    || edge_mask !== want.mask || status !== want.code
                    || queue_empty !== want.qe)
                begin
                    faults++;
                    if (faults <= 10)
                    begin
                        $display("mismatch: want row %0d col %0d mask %b status %0d empty %0d",
                                 want.row, want.col, want.mask, want.code, want.qe);
                        $display("          got  row %0d col %0d mask %b status %0d empty %0d",
                                 node_row, node_col, edge_mask, status, queue_empty);
                    end
                end
            end
        end
    end

    task automatic send_item(input logic act, input logic [COORD_W-1:0] sr,
                             input logic [COORD_W-1:0] sc, input logic tf,
                             output step_report_t rep);
        gaps_on = !(items_sent >= 700 && items_sent < 1000);
        if (gaps_on && $urandom_range(99) < 15)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(5)) @(negedge clk);
        end
        @(negedge clk);
        start      <= 1'b1;
        action     <= act;
        start_row  <= sr;
        start_col  <= sc;
        take_front <= tf;
        do @(posedge clk); while (busy);
        rep = walk_step(act, sr, sc, tf);
        step_reports.push_back(rep);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (step_reports.size() != 0 || busy)
            @(posedge clk);
        repeat (3) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_ROW_COUNT:  rows_reg = val;
            REG_COL_COUNT:  cols_reg = val;
            REG_ORDER_MODE: mode_reg = val[MODE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_walk(input int cap, input bit shake);
        step_report_t rep;
        logic [CFG_IDX_W-1:0] idx;
        int n;
        n = 0;
        while (dq_count != 0 && n < cap && items_sent < ITEM_TARGET)
        begin
            send_item(ACT_EXPAND, COORD_W'($urandom_range(31)), COORD_W'($urandom_range(31)),
                      1'($urandom_range(1)), rep);
            n++;
            if (shake && $urandom_range(199) == 0)
            begin
                idx = CFG_IDX_W'($urandom_range(2));
                write_reg(idx, (idx == REG_ORDER_MODE) ? CFG_DATA_W'($urandom_range(3))
                                                       : CFG_DATA_W'($urandom_range(7)));
            end
            else if (shake && $urandom_range(99) == 0)
                drain_results();
        end
    endtask

    task automatic test_reset_defaults();
        step_report_t rep;
        send_item(ACT_EXPAND, 5'd31, 5'd31, 1'b1, rep);
        send_item(ACT_START, 5'd16, 5'd3, 1'b0, rep);
        send_item(ACT_START, 5'd31, 5'd31, 1'b1, rep);
        send_item(ACT_START, 5'd15, 5'd0, 1'b0, rep);
        run_walk(3, 1'b0);
    endtask

    task automatic test_single_node();
        step_report_t rep;
        write_reg(REG_ROW_COUNT, 5'd0);
        write_reg(REG_COL_COUNT, 5'd0);
        send_item(ACT_START, 5'd0, 5'd0, 1'b0, rep);
        run_walk(4, 1'b0);
        send_item(ACT_EXPAND, 5'd0, 5'd0, 1'b0, rep);
        send_item(ACT_START, 5'd0, 5'd1, 1'b1, rep);
    endtask

    task automatic test_orders();
        step_report_t rep;
        logic [MODE_W-1:0] modes [4];
        modes = '{MODE_LIFO, MODE_FIFO, MODE_RANDOM, MODE_SPARE};
        write_reg(REG_ROW_COUNT, 5'd1);
        write_reg(REG_COL_COUNT, 5'd1);
        foreach (modes[m])
        begin
            write_reg(REG_ORDER_MODE, CFG_DATA_W'(modes[m]));
            send_item(ACT_START, COORD_W'($urandom_range(1)), COORD_W'($urandom_range(1)),
                      1'b0, rep);
            run_walk(3, 1'b0);
        end
    endtask

    task automatic test_largest_grid();
        step_report_t rep;
        write_reg(REG_ROW_COUNT, 5'd31);
        write_reg(REG_COL_COUNT, 5'd31);
        write_reg(REG_ORDER_MODE, CFG_DATA_W'(MODE_LIFO));
        write_reg(REG_SPARE, 5'd31);
        send_item(ACT_START, 5'd31, 5'd31, 1'b1, rep);
        run_walk(2, 1'b0);
        send_item(ACT_START, 5'd0, 5'd0, 1'b0, rep);
        run_walk(1, 1'b0);
    endtask

    task automatic test_config_mid_walk();
        step_report_t rep;
        write_reg(REG_ROW_COUNT, 5'd1);
        write_reg(REG_COL_COUNT, 5'd1);
        write_reg(REG_ORDER_MODE, CFG_DATA_W'(MODE_FIFO));
        send_item(ACT_START, 5'd1, 5'd1, 1'b0, rep);
        run_walk(1, 1'b0);
        write_reg(REG_ROW_COUNT, 5'd0);
        write_reg(REG_COL_COUNT, 5'd2);
        run_walk(CELLS + 1, 1'b0);
    endtask

    task automatic test_random_walks();
        step_report_t rep;
        int rows;
        int cols;
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(3) == 0)
            begin
                rows = ($urandom_range(9) == 0) ? 31
                     : $urandom_range(($urandom_range(3) == 0) ? 15 : 7);
                cols = (rows == 31) ? $urandom_range(3)
                     : (($urandom_range(9) == 0) ? 31 : $urandom_range(7));
                write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows));
                write_reg(REG_COL_COUNT, CFG_DATA_W'(cols));
                write_reg(REG_ORDER_MODE, CFG_DATA_W'($urandom_range(3)));
            end
            if ($urandom_range(9) == 0)
                send_item(ACT_START, COORD_W'($urandom_range(31)), COORD_W'($urandom_range(31)),
                          1'($urandom_range(1)), rep);
            else
                send_item(ACT_START, COORD_W'($urandom_range(rows_reg)),
                          COORD_W'($urandom_range(cols_reg)), 1'($urandom_range(1)), rep);
            run_walk(($urandom_range(6) == 0) ? $urandom_range(12) : CELLS + 1, 1'b1);
            repeat ($urandom_range(2))
                send_item(ACT_EXPAND, COORD_W'($urandom_range(31)), COORD_W'($urandom_range(31)),
                          1'($urandom_range(1)), rep);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = ACT_START;
        start_row  = '0;
        start_col  = '0;
        take_front = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_ROW_COUNT;
        cfg_data   = '0;
        faults     = 0;
        items_sent = 0;
        cycles     = 0;
        gaps_on    = 1'b1;
        foreach (node_mark[i])
            node_mark[i] = MARK_UNVISITED;
        dq_head  = 0;
        dq_count = 0;
        rows_reg = 5'd15;
        cols_reg = 5'd15;
        mode_reg = MODE_LIFO;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_single_node();
        test_orders();
        test_largest_grid();
        test_config_mid_walk();
        test_random_walks();

        drain_results();
        repeat (10) @(posedge clk);
        if (faults == 0 && step_reports.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
